FILE: hdl/bsk_pkg.sv
`default_nettype none

package bsk_pkg;

	localparam int unsigned FRAME_PIXELS_DEFAULT = 307200;
	localparam int unsigned INDEX_W              = 19;
	localparam int unsigned CH_W                 = 8;
	localparam logic [CH_W-1:0] THRESHOLD_RESET  = 8'd10;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// Port requests to the background memory, both taken on the accept edge
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// Compare stage status seen by the top level
	typedef struct packed {
		logic full_s1;
		logic advance_s1;
		logic capture_s1;
	} key_st_t;

	function automatic int unsigned addr_width(input int unsigned depth);
		int unsigned w;
		w = (depth > 1) ? $clog2(depth) : 1;
		return w;
	endfunction

	function automatic logic [CH_W-1:0] max3(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b, input logic [CH_W-1:0] c);
		logic [CH_W-1:0] m;
		m = a;
		if (b > m) m = b;
		if (c > m) m = c;
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/bsk_store.sv
`default_nettype none

module bsk_store #(
	parameter int unsigned FRAME_PIXELS = bsk_pkg::FRAME_PIXELS_DEFAULT
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire bsk_pkg::mem_ctl_t                             ctl,
	input  wire logic [bsk_pkg::addr_width(FRAME_PIXELS)-1:0]  addr,
	input  wire logic [bsk_pkg::CH_W-1:0]                      wdata,
	output logic      [bsk_pkg::CH_W-1:0]                      rdata,
	output logic                                               clearing
);

	localparam int unsigned ADDR_W = bsk_pkg::addr_width(FRAME_PIXELS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_PIXELS - 1);

	logic [bsk_pkg::CH_W-1:0] mem [FRAME_PIXELS];
	logic [bsk_pkg::CH_W-1:0] rdata_q;
	logic [ADDR_W-1:0]        clr_addr_q;
	logic                     clearing_q;
	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [bsk_pkg::CH_W-1:0] wval;

	// Sweep zeros through the whole store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_comb begin
		we    = clearing_q | ctl.wr_en;
		waddr = clearing_q ? clr_addr_q : addr;
		wval  = clearing_q ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wval;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

FILE: hdl/bsk_key.sv
`default_nettype none

module bsk_key (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_accept,
	input  wire logic [bsk_pkg::CH_W-1:0]  gray,
	input  wire logic                      in_range,
	input  wire logic                      capture,
	input  wire bsk_pkg::rgb_t             camera,
	input  wire bsk_pkg::rgb_t             replace,
	input  wire logic [bsk_pkg::CH_W-1:0]  bg_rd,
	input  wire logic [bsk_pkg::CH_W-1:0]  threshold,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output bsk_pkg::rgb_t                  out_rgb,
	output logic                           out_fg,
	output logic      [bsk_pkg::CH_W-1:0]  out_gray,
	output bsk_pkg::key_st_t               st
);

	logic                     valid_s1;
	logic [bsk_pkg::CH_W-1:0] gray_s1;
	logic                     in_range_s1;
	logic                     capture_s1;
	bsk_pkg::rgb_t            camera_s1;
	bsk_pkg::rgb_t            replace_s1;

	logic                     out_valid_q;
	bsk_pkg::rgb_t            rgb_q;
	logic                     fg_q;
	logic [bsk_pkg::CH_W-1:0] gray_q;

	logic                     out_free;
	logic                     advance;
	logic [bsk_pkg::CH_W-1:0] bg;
	logic [bsk_pkg::CH_W-1:0] diff;
	logic                     fg;

	assign out_free = ~out_valid_q | ~out_stall;
	assign advance  = valid_s1 & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			gray_s1     <= gray;
			in_range_s1 <= in_range;
			capture_s1  <= capture;
			camera_s1   <= camera;
			replace_s1  <= replace;
		end
		if (advance) begin
			rgb_q  <= fg ? camera_s1 : replace_s1;
			fg_q   <= fg;
			gray_q <= gray_s1;
		end
	end

	// A captured beat reads the old entry; use its own brightness instead
	always_comb begin
		if (!in_range_s1) begin
			bg = '0;
		end else if (capture_s1) begin
			bg = gray_s1;
		end else begin
			bg = bg_rd;
		end
		diff = (bg > gray_s1) ? bg - gray_s1 : gray_s1 - bg;
		fg   = diff > threshold;
	end

	assign out_valid     = out_valid_q;
	assign out_rgb       = rgb_q;
	assign out_fg        = fg_q;
	assign out_gray      = gray_q;
	assign st.full_s1    = valid_s1;
	assign st.advance_s1 = advance;
	assign st.capture_s1 = capture_s1;

endmodule

`default_nettype wire

FILE: hdl/background_subtract_key.sv
// Background subtraction keyer.
// Input channel (in_valid / in_stall) carries one camera pixel, its frame
// position, the replacement pixel at that position and a capture flag.
// Output channel (out_valid / out_stall) returns the composited pixel, the
// foreground flag and the pixel brightness, one beat for every input beat,
// in order. The threshold register is written through cfg_we / cfg_wdata
// while the block is idle; the user must ensure it, as the block does not
// enforce it. A beat is registered in the compare stage, then the output
// register. One beat is accepted every cycle unless in_stall is high: the
// background memory is read and, on capture, written on the accept edge,
// so neighbouring pixels never wait on each other. A stalled output holds
// its beat and the compare stage behind it, after which in_stall rises.
// After reset the background memory is swept to zero, one entry per cycle,
// over all FRAME_PIXELS entries; in_stall stays high during the sweep while
// threshold writes are still taken. Reset sets the threshold to 10.
`default_nettype none

module background_subtract_key #(
	parameter int unsigned FRAME_PIXELS = bsk_pkg::FRAME_PIXELS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bsk_pkg::CH_W-1:0]        cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [bsk_pkg::INDEX_W-1:0]     pixel_index,
	input  wire logic [bsk_pkg::CH_W-1:0]        camera_red,
	input  wire logic [bsk_pkg::CH_W-1:0]        camera_green,
	input  wire logic [bsk_pkg::CH_W-1:0]        camera_blue,
	input  wire logic [bsk_pkg::CH_W-1:0]        replace_red,
	input  wire logic [bsk_pkg::CH_W-1:0]        replace_green,
	input  wire logic [bsk_pkg::CH_W-1:0]        replace_blue,
	input  wire logic                            capture_background,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [bsk_pkg::CH_W-1:0]        out_red,
	output logic      [bsk_pkg::CH_W-1:0]        out_green,
	output logic      [bsk_pkg::CH_W-1:0]        out_blue,
	output logic                                 is_foreground,
	output logic      [bsk_pkg::CH_W-1:0]        gray_level
);

	localparam int unsigned ADDR_W = bsk_pkg::addr_width(FRAME_PIXELS);

	logic [bsk_pkg::CH_W-1:0] threshold_q;
	logic                     in_accept;
	logic [bsk_pkg::CH_W-1:0] gray;
	logic [31:0]              index_ext;
	logic                     in_range;
	logic                     capture;
	logic [ADDR_W-1:0]        addr;
	logic [bsk_pkg::CH_W-1:0] bg_rd;
	logic                     clearing;
	bsk_pkg::mem_ctl_t        mem_ctl;
	bsk_pkg::key_st_t         key_st;
	bsk_pkg::rgb_t            camera;
	bsk_pkg::rgb_t            replace;
	bsk_pkg::rgb_t            out_rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bsk_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	assign in_stall  = clearing | (key_st.full_s1 & ~key_st.advance_s1);
	assign in_accept = in_valid & ~in_stall;

	always_comb begin
		gray          = bsk_pkg::max3(camera_red, camera_green, camera_blue);
		index_ext     = 32'(pixel_index);
		in_range      = index_ext < FRAME_PIXELS;
		addr          = index_ext[ADDR_W-1:0];
		capture       = capture_background & in_range;
		mem_ctl.rd_en = in_accept;
		mem_ctl.wr_en = in_accept & capture;
		camera        = '{red: camera_red, green: camera_green, blue: camera_blue};
		replace       = '{red: replace_red, green: replace_green, blue: replace_blue};
	end

	bsk_store #(
		.FRAME_PIXELS(FRAME_PIXELS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.addr     (addr),
		.wdata    (gray),
		.rdata    (bg_rd),
		.clearing (clearing)
	);

	bsk_key u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.gray      (gray),
		.in_range  (in_range),
		.capture   (capture),
		.camera    (camera),
		.replace   (replace),
		.bg_rd     (bg_rd),
		.threshold (threshold_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_rgb   (out_rgb),
		.out_fg    (is_foreground),
		.out_gray  (gray_level),
		.st        (key_st)
	);

	assign out_red   = out_rgb.red;
	assign out_green = out_rgb.green;
	assign out_blue  = out_rgb.blue;

	// A captured pixel always keys as background
	assert property (@(posedge clk) disable iff (!arst_n)
		key_st.advance_s1 && key_st.capture_s1 |=> out_valid && !is_foreground)
		else $error("captured pixel keyed as foreground");

	// No beat may enter while the compare stage is full and cannot drain
	assert property (@(posedge clk) disable iff (!arst_n)
		key_st.full_s1 && out_valid && out_stall |-> in_stall)
		else $error("beat accepted over a held compare stage");

	// A foreground beat carries the camera pixel, whose largest channel is the brightness
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_foreground |->
		(out_red <= gray_level) && (out_green <= gray_level) && (out_blue <= gray_level)
		&& ((out_red == gray_level) || (out_green == gray_level)
		|| (out_blue == gray_level)))
		else $error("foreground pixel does not match its brightness");

endmodule

`default_nettype wire
